// ===== rtl/core/sps_pkg.sv =====
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types and constants of the shortest path search core.
// ----------------------------------------------------------------------------
package sps_pkg;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int VTX_W   = 10;
    localparam int WGT_W   = 16;
    localparam int DIST_W  = 32;
    localparam int CFG_W   = 11;
    localparam int STAT_W  = 2;

    // Defaults of the module parameters
    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_MAX_EDGES    = 4096;

    // Vertex count after reset
    localparam int VCOUNT_RESET = 1024;

    // Queue depths between the parts
    localparam int JOBQ_DEPTH = 4;
    localparam int RESQ_DEPTH = 4;

    localparam logic [DIST_W-1:0] DIST_TOP = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_RANGE   = 2'd2,
        ST_UNREACH = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        JOB_DONE  = 2'd0,
        JOB_ADD   = 2'd1,
        JOB_CLEAR = 2'd2,
        JOB_QUERY = 2'd3
    } t_job_kind;

    typedef struct packed {
        t_job_kind        kind;
        t_status          status;
        logic [VTX_W-1:0] va;
        logic [VTX_W-1:0] vb;
        logic [WGT_W-1:0] weight;
    } t_job;

    typedef struct packed {
        t_status           status;
        logic [DIST_W-1:0] length;
    } t_result;

    typedef struct packed {
        logic [VTX_W-1:0] a;
        logic [VTX_W-1:0] b;
        logic [WGT_W-1:0] weight;
    } t_edge;

    typedef struct packed {
        logic              reached;
        logic              settled;
        logic [DIST_W-1:0] length;
    } t_vword;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_INIT,
        ENG_SCAN,
        ENG_RLX_RD,
        ENG_RLX_EV,
        ENG_RLX_WR
    } t_eng_state;

endpackage

// ===== rtl/core/shortest_path_search_core.sv =====
// ----------------------------------------------------------------------------
// shortest_path_search_core
// Edge store with single-pair shortest path queries (Dijkstra).
// ----------------------------------------------------------------------------
// Input side is a queue: drive the command fields with push; a transaction is
// taken when push is high and full is low. Result side is a queue too: status
// and distance are valid while empty is low and leave on pop. Every input
// transaction yields exactly one result, in order.
// Adds, clears, range errors and the unused command flow through a 4-entry
// job queue into the engine at one per cycle while the engine is idle and
// the result queue has room; such a result is registered in the job queue,
// then in the result queue. A query wipes the working store, then per settled
// vertex scans the vertices in use for the minimum and relaxes each stored
// edge. One job runs at a time; items behind a query wait in the job queue.
// When the receiver stalls, results collect in a 4-entry result queue; the
// engine stops taking jobs once it is full, and full rises on the input.
// Reset empties both queues, clears the edge count and sets the vertex count
// to 1024; no memory sweep is needed. Write the vertex count only when idle.
// ----------------------------------------------------------------------------
module shortest_path_search_core #(
    parameter int MAX_VERTICES = sps_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = sps_pkg::DEF_MAX_EDGES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [sps_pkg::CFG_W-1:0]  i_cfg_wr_data,
    input  logic                       push,
    output logic                       full,
    input  logic [sps_pkg::CMD_W-1:0]  i_command,
    input  logic [sps_pkg::VTX_W-1:0]  i_first_vertex,
    input  logic [sps_pkg::VTX_W-1:0]  i_second_vertex,
    input  logic [sps_pkg::WGT_W-1:0]  i_edge_weight,
    output logic                       empty,
    input  logic                       pop,
    output logic [sps_pkg::STAT_W-1:0] o_status,
    output logic [sps_pkg::DIST_W-1:0] o_distance
);
    import sps_pkg::*;

    t_job             front_job;
    t_job             job_head;
    t_result          eng_res;
    t_result          res_head;
    logic [CFG_W-1:0] live_count;
    logic             job_empty;
    logic             job_pop;
    logic             res_full;
    logic             res_push;

    // classification
    sps_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_command       (i_command),
        .i_first_vertex  (i_first_vertex),
        .i_second_vertex (i_second_vertex),
        .i_edge_weight   (i_edge_weight),
        .o_job           (front_job),
        .o_live_count    (live_count)
    );

    // job queue
    sps_fifo #(
        .W     ($bits(t_job)),
        .DEPTH (JOBQ_DEPTH)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (front_job),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_rdata (job_head),
        .o_empty (job_empty)
    );

    // engine
    sps_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_live_count (live_count),
        .i_job        (job_head),
        .i_job_empty  (job_empty),
        .o_job_pop    (job_pop),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res        (eng_res)
    );

    // result queue
    sps_fifo #(
        .W     ($bits(t_result)),
        .DEPTH (RESQ_DEPTH)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (eng_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (res_head),
        .o_empty (empty)
    );

    assign o_status   = res_head.status;
    assign o_distance = res_head.length;

endmodule

// ===== rtl/core/sps_fifo.sv =====
// ----------------------------------------------------------------------------
// sps_fifo
// Small synchronous FIFO used for the job queue and the result queue.
// ----------------------------------------------------------------------------
module sps_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_wdata,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_rdata,
    output logic         o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

// ===== rtl/core/sps_front.sv =====
// ----------------------------------------------------------------------------
// sps_front
// Holds the vertex count register and classifies each incoming transaction
// into a job for the engine: range errors and no-op commands are resolved here.
// ----------------------------------------------------------------------------
module sps_front #(
    parameter int MAX_VERTICES = sps_pkg::DEF_MAX_VERTICES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [sps_pkg::CFG_W-1:0]   i_cfg_wr_data,
    input  logic [sps_pkg::CMD_W-1:0]   i_command,
    input  logic [sps_pkg::VTX_W-1:0]   i_first_vertex,
    input  logic [sps_pkg::VTX_W-1:0]   i_second_vertex,
    input  logic [sps_pkg::WGT_W-1:0]   i_edge_weight,
    output sps_pkg::t_job               o_job,
    output logic [sps_pkg::CFG_W-1:0]   o_live_count
);
    import sps_pkg::*;

    logic [CFG_W-1:0] r_vcount;
    logic             range_ok;

    // vertex count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= CFG_W'(VCOUNT_RESET);
        end else if (i_cfg_wr_en) begin
            r_vcount <= i_cfg_wr_data;
        end
    end

    // count in use, capped at the build limit
    assign o_live_count = (32'(r_vcount) < MAX_VERTICES) ? r_vcount : CFG_W'(MAX_VERTICES);

    assign range_ok = ({1'b0, i_first_vertex} < o_live_count)
                   && ({1'b0, i_second_vertex} < o_live_count);

    // classify
    always_comb begin
        o_job.kind   = JOB_DONE;
        o_job.status = ST_OK;
        o_job.va     = i_first_vertex;
        o_job.vb     = i_second_vertex;
        o_job.weight = i_edge_weight;
        unique case (t_cmd'(i_command))
            CMD_ADD: begin
                if (range_ok) o_job.kind = JOB_ADD;
                else          o_job.status = ST_RANGE;
            end
            CMD_QUERY: begin
                if (range_ok) o_job.kind = JOB_QUERY;
                else          o_job.status = ST_RANGE;
            end
            CMD_CLEAR: o_job.kind = JOB_CLEAR;
            CMD_NONE:  o_job.kind = JOB_DONE;
        endcase
    end

endmodule

// ===== rtl/core/sps_back.sv =====
// ----------------------------------------------------------------------------
// sps_back
// Engine: owns the edge store, runs adds and clears as it takes them, and walks
// the graph for queries with a linear-scan Dijkstra sequencer.
// ----------------------------------------------------------------------------
module sps_back #(
    parameter int MAX_VERTICES = sps_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = sps_pkg::DEF_MAX_EDGES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [sps_pkg::CFG_W-1:0] i_live_count,
    input  sps_pkg::t_job             i_job,
    input  logic                      i_job_empty,
    output logic                      o_job_pop,
    input  logic                      i_res_full,
    output logic                      o_res_push,
    output sps_pkg::t_result          o_res
);
    import sps_pkg::*;

    localparam int VDEPTH = (MAX_VERTICES < (1 << VTX_W)) ? MAX_VERTICES : (1 << VTX_W);
    localparam int VA_W   = $clog2(VDEPTH);
    localparam int EA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int TOT_W  = $clog2(MAX_EDGES + 1);

    // stores
    t_edge  r_emem [MAX_EDGES];
    t_vword r_vmem [VDEPTH];

    t_eng_state       r_state, n_state;
    logic [TOT_W-1:0] r_total, n_total;
    logic [TOT_W-1:0] r_eidx, n_eidx;
    logic [CFG_W-1:0] r_vidx, n_vidx;
    logic [VTX_W-1:0] r_src, n_src;
    logic [VTX_W-1:0] r_tgt, n_tgt;
    logic [VTX_W-1:0] r_cur, n_cur;
    logic [VTX_W-1:0] r_nbr, n_nbr;
    logic [VTX_W-1:0] r_pidx, n_pidx;
    logic [VTX_W-1:0] r_best, n_best;
    logic [DIST_W-1:0] r_bestd, n_bestd;
    logic [DIST_W-1:0] r_curd, n_curd;
    logic             r_pend, n_pend;
    logic             r_found, n_found;
    t_edge            r_edata;
    t_vword           r_vdata;

    logic             emem_we;
    t_edge            emem_wdata;
    logic             vmem_we;
    logic [VA_W-1:0]  vmem_waddr;
    t_vword           vmem_wdata;
    logic [VA_W-1:0]  vmem_raddr;
    logic [CFG_W-1:0] scan_n;
    logic [TOT_W-1:0] eidx_nx;
    logic [DIST_W:0]  sum;
    logic [DIST_W-1:0] cand;
    logic             edge_in, hit_a, hit_b;
    logic [VTX_W-1:0] nbr;

    assign scan_n = (i_live_count < CFG_W'(VDEPTH)) ? i_live_count : CFG_W'(VDEPTH);
    assign eidx_nx = r_eidx + 1'b1;

    // saturating candidate distance
    assign sum  = {1'b0, r_curd} + (DIST_W + 1)'(r_edata.weight);
    assign cand = sum[DIST_W] ? DIST_TOP : sum[DIST_W-1:0];

    // edge match against the vertex being settled
    assign edge_in = ({1'b0, r_edata.a} < i_live_count) && ({1'b0, r_edata.b} < i_live_count);
    assign hit_a   = (r_edata.a == r_cur);
    assign hit_b   = (r_edata.b == r_cur);
    assign nbr     = hit_a ? r_edata.b : r_edata.a;

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_total    = r_total;
        n_eidx     = r_eidx;
        n_vidx     = r_vidx;
        n_src      = r_src;
        n_tgt      = r_tgt;
        n_cur      = r_cur;
        n_nbr      = r_nbr;
        n_pidx     = r_pidx;
        n_best     = r_best;
        n_bestd    = r_bestd;
        n_curd     = r_curd;
        n_pend     = 1'b0;
        n_found    = r_found;
        o_job_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '{status: ST_OK, length: '0};
        emem_we    = 1'b0;
        emem_wdata = '{a: i_job.va, b: i_job.vb, weight: i_job.weight};
        vmem_we    = 1'b0;
        vmem_waddr = r_vidx[VA_W-1:0];
        vmem_wdata = '{reached: 1'b0, settled: 1'b0, length: '0};
        vmem_raddr = r_vidx[VA_W-1:0];

        unique case (r_state)
            ENG_IDLE: begin
                if (!i_job_empty && !i_res_full) begin
                    o_job_pop = 1'b1;
                    unique case (i_job.kind)
                        JOB_DONE: begin
                            o_res_push = 1'b1;
                            o_res.status = i_job.status;
                        end
                        JOB_ADD: begin
                            o_res_push = 1'b1;
                            if (r_total >= TOT_W'(MAX_EDGES)) begin
                                o_res.status = ST_FULL;
                            end else begin
                                emem_we = 1'b1;
                                n_total = r_total + 1'b1;
                            end
                        end
                        JOB_CLEAR: begin
                            o_res_push = 1'b1;
                            n_total = '0;
                        end
                        JOB_QUERY: begin
                            n_src   = i_job.va;
                            n_tgt   = i_job.vb;
                            n_vidx  = '0;
                            n_state = ENG_INIT;
                        end
                    endcase
                end
            end

            // wipe working storage, seed the source
            ENG_INIT: begin
                vmem_we = 1'b1;
                vmem_wdata.reached = (r_vidx[VTX_W-1:0] == r_src);
                if (r_vidx + 1'b1 >= scan_n) begin
                    n_vidx  = '0;
                    n_found = 1'b0;
                    n_state = ENG_SCAN;
                end else begin
                    n_vidx = r_vidx + 1'b1;
                end
            end

            // find the closest reached, unsettled vertex
            ENG_SCAN: begin
                if (r_vidx < scan_n) begin
                    n_pend = 1'b1;
                    n_pidx = r_vidx[VTX_W-1:0];
                    n_vidx = r_vidx + 1'b1;
                end
                if (r_pend && r_vdata.reached && !r_vdata.settled
                        && (!r_found || r_vdata.length < r_bestd)) begin
                    n_found = 1'b1;
                    n_best  = r_pidx;
                    n_bestd = r_vdata.length;
                end
                if (r_vidx >= scan_n && !r_pend) begin
                    if (!r_found) begin
                        o_res_push   = 1'b1;
                        o_res.status = ST_UNREACH;
                        n_state      = ENG_IDLE;
                    end else if (r_best == r_tgt) begin
                        o_res_push   = 1'b1;
                        o_res.length = r_bestd;
                        n_state      = ENG_IDLE;
                    end else begin
                        vmem_we    = 1'b1;
                        vmem_waddr = r_best[VA_W-1:0];
                        vmem_wdata = '{reached: 1'b1, settled: 1'b1, length: r_bestd};
                        n_cur      = r_best;
                        n_curd     = r_bestd;
                        n_vidx     = '0;
                        n_found    = 1'b0;
                        n_eidx     = '0;
                        n_state    = (r_total == '0) ? ENG_SCAN : ENG_RLX_RD;
                    end
                end
            end

            ENG_RLX_RD: n_state = ENG_RLX_EV;

            // edge data ready: fetch the neighbor if the edge touches cur
            ENG_RLX_EV: begin
                if (edge_in && (hit_a || hit_b) && nbr != r_cur) begin
                    vmem_raddr = nbr[VA_W-1:0];
                    n_nbr      = nbr;
                    n_state    = ENG_RLX_WR;
                end else if (eidx_nx < r_total) begin
                    n_eidx  = eidx_nx;
                    n_state = ENG_RLX_RD;
                end else begin
                    n_vidx  = '0;
                    n_found = 1'b0;
                    n_state = ENG_SCAN;
                end
            end

            // relax the neighbor
            ENG_RLX_WR: begin
                if (!r_vdata.settled && (!r_vdata.reached || cand < r_vdata.length)) begin
                    vmem_we    = 1'b1;
                    vmem_waddr = r_nbr[VA_W-1:0];
                    vmem_wdata = '{reached: 1'b1, settled: 1'b0, length: cand};
                end
                if (eidx_nx < r_total) begin
                    n_eidx  = eidx_nx;
                    n_state = ENG_RLX_RD;
                end else begin
                    n_vidx  = '0;
                    n_found = 1'b0;
                    n_state = ENG_SCAN;
                end
            end

            default: n_state = ENG_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ENG_IDLE;
            r_total <= '0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_pend  <= n_pend;
            r_found <= n_found;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_eidx  <= n_eidx;
        r_vidx  <= n_vidx;
        r_src   <= n_src;
        r_tgt   <= n_tgt;
        r_cur   <= n_cur;
        r_nbr   <= n_nbr;
        r_pidx  <= n_pidx;
        r_best  <= n_best;
        r_bestd <= n_bestd;
        r_curd  <= n_curd;
    end

    // edge store
    always_ff @(posedge i_clk) begin
        if (emem_we) begin
            r_emem[r_total[EA_W-1:0]] <= emem_wdata;
        end
        r_edata <= r_emem[r_eidx[EA_W-1:0]];
    end

    // vertex working store
    always_ff @(posedge i_clk) begin
        if (vmem_we) begin
            r_vmem[vmem_waddr] <= vmem_wdata;
        end
        r_vdata <= r_vmem[vmem_raddr];
    end

`ifndef SYNTHESIS
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full) else $error("result pushed into full queue");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> (r_state == ENG_IDLE)) else $error("job popped while busy");
    a_total_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_total) <= MAX_EDGES) else $error("edge count over capacity");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_job_pop && i_job.kind == JOB_CLEAR) |=> (r_total == '0))
        else $error("clear left edges behind");
    a_wr_after_ev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ENG_RLX_WR) |-> ($past(r_state) == ENG_RLX_EV))
        else $error("relax write without edge evaluation");
`endif

endmodule
